// File: hdl/lsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lsc_pkg;
   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_FILL   = 2'd1;
   localparam logic [1:0] FUNC_WRITE  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned SLOT_W = 6;
   localparam int unsigned CSR_CAPACITY_LIMIT = 0;
   localparam logic [6:0] CAPACITY_RESET = 7'd64;
endpackage
`default_nettype wire

// File: hdl/lsc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module lsc_cell #(
   parameter int unsigned RANK_W = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [31:0]       sector,
   input  wire logic              compare_en,
   output logic                   match,
   input  wire logic              sel,
   input  wire logic              evict_sel,
   input  wire logic              upd,
   input  wire logic              new_entry,
   input  wire logic [RANK_W-1:0] ref_rank,
   input  wire logic              set_dirty,
   output logic                   valid,
   output logic                   dirty,
   output logic [RANK_W-1:0]      rank,
   output logic [31:0]            tag
);
   logic              valid_ff, dirty_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [31:0]       tag_ff;

   assign valid = valid_ff;
   assign dirty = dirty_ff;
   assign rank  = rank_ff;
   assign tag   = tag_ff;
   assign match = compare_en && valid_ff && (tag_ff == sector);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         rank_ff  <= '0;
      end else if (upd) begin
         if (sel) begin
            rank_ff  <= '0;
            valid_ff <= 1'b1;
            if (new_entry) begin
               dirty_ff <= set_dirty;
            end else if (set_dirty) begin
               dirty_ff <= 1'b1;
            end
         end else if (valid_ff && !evict_sel &&
                      (new_entry || rank_ff < ref_rank)) begin
            rank_ff <= rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd && sel && new_entry) begin
         tag_ff <= sector;
      end
   end
endmodule
`default_nettype wire

// File: hdl/lru_sector_cache_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully associative LRU tag/metadata controller for a write-back sector cache.
// Request: pulse start with req_func/req_sector while busy is low. The
// request is taken on that edge; busy stays high until the result strobe.
// Result: rsp_valid is high for one cycle with hit, slot, load_needed,
// evicted, evicted_sector and writeback; the receiver cannot stall it.
// Steps from start to rsp_valid: compare, victim pick by matching the oldest
// rank in every cell, row update, result. One request at a time: a new
// request is taken only once busy is low again.
// Each cell of the row holds one entry: tag, valid, dirty and recency rank
// (0 is most recent). All cells compare the tag in parallel and update their
// ranks in the same cycle.
// CSR: register 0 at address 0 is capacity_limit (7 bits, reset 64).
// Reset (synchronous) clears all valid, dirty and rank state and sets the
// limit to 64; tags are undefined until written.
module lru_sector_cache_controller #(
   parameter int unsigned ENTRIES = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [1:0]   req_func,
   input  wire logic [31:0]  req_sector,
   output logic              rsp_valid,
   output logic              rsp_hit,
   output logic [5:0]        rsp_slot,
   output logic              rsp_load_needed,
   output logic              rsp_evicted,
   output logic [31:0]       rsp_evicted_sector,
   output logic              rsp_writeback,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [0:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {S_IDLE, S_MATCH, S_SCAN, S_UPD, S_RSP} state_type;

   state_type        state_ff;
   logic [1:0]       func_ff;
   logic [31:0]      sector_ff;
   logic [6:0]       limit_ff;
   logic [CNT_W-1:0] count_ff;
   logic             hit_ff, alloc_ff, evict_ff, wb_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [IDX_W-1:0] free_ff;
   logic             free_any_ff;
   logic [31:0]      evsec_ff;
   logic [IDX_W-1:0] ref_rank_ff;
   logic [IDX_W-1:0] hit_idx_ff;

   logic [ENTRIES-1:0] match, valid, dirty;
   logic [IDX_W-1:0]   rank [ENTRIES];
   logic [31:0]        tag  [ENTRIES];
   logic               upd;

   assign csr_pready = 1'b1;
   assign csr_prdata = {25'd0, limit_ff};
   assign busy = (state_ff != S_IDLE);
   assign upd  = (state_ff == S_UPD);

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lsc_cell #(.RANK_W(IDX_W)) u_cell (
         .clock(clock), .reset(reset), .sector(sector_ff),
         .compare_en(state_ff == S_MATCH), .match(match[g]),
         .sel(slot_ff == IDX_W'(g)),
         .evict_sel(evict_ff && (slot_ff == IDX_W'(g))),
         .upd(upd && (hit_ff || alloc_ff)),
         .new_entry(!hit_ff), .ref_rank(ref_rank_ff),
         .set_dirty(func_ff == lsc_pkg::FUNC_WRITE),
         .valid(valid[g]), .dirty(dirty[g]), .rank(rank[g]), .tag(tag[g])
      );
   end

   // valid ranks are always 0..count-1, so the LRU entry holds rank count-1
   logic [IDX_W-1:0] lru_rank;
   assign lru_rank = IDX_W'(count_ff - 1'b1);

   // first match / first free / lru pick (lowest index wins)
   logic             m_any, f_any;
   logic [IDX_W-1:0] m_idx, f_idx, l_idx;
   always_comb begin
      m_any = 1'b0; m_idx = '0; f_any = 1'b0; f_idx = '0;
      l_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            m_any = 1'b1; m_idx = IDX_W'(i);
         end
         if (!valid[i]) begin
            f_any = 1'b1; f_idx = IDX_W'(i);
         end
         if (valid[i] && rank[i] == lru_rank) begin
            l_idx = IDX_W'(i);
         end
      end
   end

   logic [6:0] lim;
   always_comb begin
      lim = limit_ff;
      if (lim == 7'd0) lim = 7'd1;
      if (32'(lim) > ENTRIES) lim = 7'(ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         limit_ff <= lsc_pkg::CAPACITY_RESET;
         count_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == 1'(lsc_pkg::CSR_CAPACITY_LIMIT)) begin
            limit_ff <= csr_pwdata[6:0];
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff   <= req_func;
                  sector_ff <= req_sector;
                  state_ff  <= S_MATCH;
               end
            end
            S_MATCH: begin
               hit_ff      <= m_any;
               hit_idx_ff  <= m_idx;
               free_any_ff <= f_any;
               free_ff     <= f_idx;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               evict_ff <= 1'b0;
               wb_ff <= 1'b0;
               evsec_ff <= '0;
               alloc_ff <= 1'b0;
               if (hit_ff) begin
                  slot_ff <= hit_idx_ff;
                  ref_rank_ff <= rank[hit_idx_ff];
               end else if (func_ff == lsc_pkg::FUNC_FILL ||
                            func_ff == lsc_pkg::FUNC_WRITE) begin
                  alloc_ff <= 1'b1;
                  if ({1'b0, count_ff} >= (CNT_W + 1)'(lim) || !free_any_ff) begin
                     slot_ff  <= l_idx;
                     evict_ff <= 1'b1;
                     wb_ff    <= dirty[l_idx];
                     evsec_ff <= tag[l_idx];
                  end else begin
                     slot_ff <= free_ff;
                  end
               end else begin
                  slot_ff <= '0;
               end
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (alloc_ff && !evict_ff) count_ff <= count_ff + 1'b1;
               state_ff <= S_RSP;
            end
            S_RSP: begin
               rsp_valid <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RSP) begin
         rsp_hit            <= hit_ff;
         rsp_slot           <= 6'(slot_ff);
         rsp_load_needed    <= alloc_ff;
         rsp_evicted        <= evict_ff;
         rsp_evicted_sector <= evsec_ff;
         rsp_writeback      <= wb_ff;
      end
   end

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
   a_hit_no_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_load_needed && !rsp_evicted)
      else $error("hit with allocation");
   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_writeback |-> rsp_evicted) else $error("wb without evict");
   a_count: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= (CNT_W + 1)'(ENTRIES)) else $error("count overflow");
endmodule
`default_nettype wire
